[hw/rtl/pwmf_pkg.sv]
// ----------------------------------------------------------------------------
// pwmf_pkg
// Shared types and constants of the pulse width median filter.
// ----------------------------------------------------------------------------
package pwmf_pkg;

   localparam int TIME_W  = 32;
   localparam int WIDTH_W = 16;
   localparam int TICKS_W = 8;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_TICKS_PER_US = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WIDTH_LIMIT  = 1'd1;

   localparam logic [TICKS_W-1:0] TICKS_RESET = 8'd80;
   localparam logic [WIDTH_W-1:0] LIMIT_RESET = 16'd4166;
   localparam logic [WIDTH_W-1:0] WIDTH_MAX   = '1;

   localparam logic EDGE_RISE = 1'b0;
   localparam logic EDGE_FALL = 1'b1;

   // divider retires two quotient bits per cycle
   localparam int DIV_STEPS = TIME_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOAD,
      ST_RANK,
      ST_SELECT
   } pwmf_state_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic step;
   } pwmf_cell_ctl_type;

endpackage

[hw/rtl/pwmf_channels.sv]
// ----------------------------------------------------------------------------
// pwmf_channels
// Valid/ready channel interfaces for capture events and filtered results.
// ----------------------------------------------------------------------------
interface pwmf_req_if;
   import pwmf_pkg::*;

   logic              valid;
   logic              ready;
   logic              req_type;
   logic [TIME_W-1:0] capture_time;

   modport source (output valid, output req_type, output capture_time, input ready);
   modport sink   (input valid, input req_type, input capture_time, output ready);
endinterface

interface pwmf_rsp_if;
   import pwmf_pkg::*;

   logic               valid;
   logic               ready;
   logic [WIDTH_W-1:0] filtered_width;
   logic               median_accepted;

   modport source (output valid, output filtered_width, output median_accepted,
                   input ready);
   modport sink   (input valid, input filtered_width, input median_accepted,
                   output ready);
endinterface

[hw/rtl/pwmf_divider.sv]
// ----------------------------------------------------------------------------
// pwmf_divider
// Iterative restoring divider, 32-bit dividend by 8-bit divisor, two
// quotient bits per cycle. A zero divisor gives an all-ones quotient.
// ----------------------------------------------------------------------------
module pwmf_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pwmf_pkg::TIME_W-1:0]   dividend,
   input  logic [pwmf_pkg::TICKS_W-1:0]  divisor,
   output logic                          done,
   output logic [pwmf_pkg::TIME_W-1:0]   quotient
);
   import pwmf_pkg::*;

   localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   logic [TIME_W-1:0]    quo_ff, quo_in;
   logic [TICKS_W-1:0]   rem_ff, rem_in;
   logic [TICKS_W-1:0]   div_ff;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;

   logic [TICKS_W:0] r1, r1s, r2, r2s;
   logic             ge1, ge2;

   always_comb begin
      r1  = {rem_ff, quo_ff[TIME_W-1]};
      ge1 = r1 >= {1'b0, div_ff};
      r1s = ge1 ? r1 - {1'b0, div_ff} : r1;
      r2  = {r1s[TICKS_W-1:0], quo_ff[TIME_W-2]};
      ge2 = r2 >= {1'b0, div_ff};
      r2s = ge2 ? r2 - {1'b0, div_ff} : r2;

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[TIME_W-3:0], ge1, ge2};
         rem_in = r2s[TICKS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hw/rtl/pwmf_cell.sv]
// ----------------------------------------------------------------------------
// pwmf_cell
// One window entry. Shifts entries along the chain on a new width and
// counts its rank while the other entries circulate past it.
// ----------------------------------------------------------------------------
module pwmf_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pwmf_pkg::pwmf_cell_ctl_type    ctl,
   input  logic [pwmf_pkg::WIDTH_W-1:0]   shift_in,
   input  logic [pwmf_pkg::WIDTH_W-1:0]   circ_val_in,
   input  logic [IDX_W-1:0]               circ_tag_in,
   output logic [pwmf_pkg::WIDTH_W-1:0]   entry,
   output logic [pwmf_pkg::WIDTH_W-1:0]   circ_val,
   output logic [IDX_W-1:0]               circ_tag,
   output logic [IDX_W-1:0]               rank
);
   import pwmf_pkg::*;

   localparam logic [IDX_W-1:0] MY_TAG = IDX_W'(INDEX);

   logic [WIDTH_W-1:0] entry_ff;
   logic [WIDTH_W-1:0] circ_val_ff;
   logic [IDX_W-1:0]   circ_tag_ff;
   logic [IDX_W-1:0]   rank_ff;
   logic               below;

   // ties ordered by position so ranks form a permutation
   assign below = (circ_val_in < entry_ff) ||
                  ((circ_val_in == entry_ff) && (circ_tag_in < MY_TAG));

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (ctl.shift) begin
         entry_ff <= shift_in;
      end
      if (ctl.load) begin
         circ_val_ff <= entry_ff;
         circ_tag_ff <= MY_TAG;
         rank_ff     <= '0;
      end else if (ctl.step) begin
         circ_val_ff <= circ_val_in;
         circ_tag_ff <= circ_tag_in;
         rank_ff     <= rank_ff + IDX_W'(below);
      end
   end

   assign entry    = entry_ff;
   assign circ_val = circ_val_ff;
   assign circ_tag = circ_tag_ff;
   assign rank     = rank_ff;

endmodule

[hw/rtl/pulse_width_median_filter.sv]
// ----------------------------------------------------------------------------
// pulse_width_median_filter
// Pulse width capture with a median-of-window filter.
// ----------------------------------------------------------------------------
// Capture words enter on req_ch: req_type 0 (rising) stores capture_time,
// req_type 1 (falling) measures the pulse and yields one word on rsp_ch.
// A rising edge word is taken in the idle state and gives no result.
// A falling edge word: the width (time difference over ticks_per_microsecond,
// saturated to 16 bits) comes from an iterative divider, then shifts into
// a chain of WINDOW_SIZE cells (oldest drops out). The entries circulate
// around the chain while every cell counts its rank; the cell of middle
// rank supplies the median.
// The next word is taken in the same cycle the result appears; no word is
// taken while a falling edge word is being processed.
// The result sits in an output register; a stalled receiver holds it while
// the next word is processed, and a new result waits only if the previous
// one has not yet been taken.
// Reset (synchronous) clears the window, the stored rise time, the held
// width and the registers to 80 ticks/us and a 4166 us limit.
// csr_we writes register csr_addr: 0 ticks per microsecond, 1 width limit.
// ----------------------------------------------------------------------------
module pulse_width_median_filter #(
   parameter int WINDOW_SIZE = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   pwmf_req_if.sink                          req_ch,
   pwmf_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [pwmf_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [pwmf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pwmf_pkg::*;

   localparam int               IDX_W     = $clog2(WINDOW_SIZE);
   localparam logic [IDX_W-1:0] MID_RANK  = IDX_W'(WINDOW_SIZE / 2);
   localparam logic [IDX_W-1:0] RANK_LAST = IDX_W'(WINDOW_SIZE - 2);

   pwmf_state_type state_ff, state_in;

   logic [TICKS_W-1:0] ticks_ff;
   logic [WIDTH_W-1:0] limit_ff;
   logic [TIME_W-1:0]  rise_ff;
   logic [WIDTH_W-1:0] held_ff, held_in;
   logic               acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   step_ff, step_in;

   logic               accept;
   logic               div_start;
   logic               div_done;
   logic [TIME_W-1:0]  div_quo;
   logic [WIDTH_W-1:0] new_width;
   logic               out_load;

   pwmf_cell_ctl_type  cell_ctl;

   logic [WIDTH_W-1:0] entry    [WINDOW_SIZE];
   logic [WIDTH_W-1:0] circ_val [WINDOW_SIZE];
   logic [IDX_W-1:0]   circ_tag [WINDOW_SIZE];
   logic [IDX_W-1:0]   rank     [WINDOW_SIZE];
   logic [WINDOW_SIZE-1:0] mid_hit;
   logic [WIDTH_W-1:0] median;

   assign accept = req_ch.valid && req_ch.ready;

   pwmf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_ch.capture_time - rise_ff),
      .divisor  (ticks_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign new_width = (div_quo[TIME_W-1:WIDTH_W] != '0) ? WIDTH_MAX
                                                        : div_quo[WIDTH_W-1:0];

   for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
      logic [WIDTH_W-1:0] shift_src;
      if (i == 0) begin : g_head
         assign shift_src = new_width;
      end else begin : g_body
         assign shift_src = entry[i-1];
      end

      pwmf_cell #(
         .INDEX (i),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .shift_in    (shift_src),
         .circ_val_in (circ_val[(i + WINDOW_SIZE - 1) % WINDOW_SIZE]),
         .circ_tag_in (circ_tag[(i + WINDOW_SIZE - 1) % WINDOW_SIZE]),
         .entry       (entry[i]),
         .circ_val    (circ_val[i]),
         .circ_tag    (circ_tag[i]),
         .rank        (rank[i])
      );

      assign mid_hit[i] = rank[i] == MID_RANK;
   end

   always_comb begin
      median = '0;
      for (int k = 0; k < WINDOW_SIZE; k++) begin
         median = median | (mid_hit[k] ? entry[k] : '0);
      end
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      held_in        = held_ff;
      acc_in         = acc_ff;
      div_start      = 1'b0;
      out_load       = 1'b0;
      cell_ctl       = '0;
      req_ch.ready   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (accept && req_ch.req_type == EDGE_FALL) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               cell_ctl.shift = 1'b1;
               state_in       = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cell_ctl.load = 1'b1;
            step_in       = '0;
            state_in      = ST_RANK;
         end
         ST_RANK: begin
            cell_ctl.step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == RANK_LAST) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_load = 1'b1;
               acc_in   = median < limit_ff;
               if (median < limit_ff) begin
                  held_in = median;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_ch.ready) || out_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ticks_ff     <= TICKS_RESET;
         limit_ff     <= LIMIT_RESET;
         rise_ff      <= '0;
         held_ff      <= '0;
         acc_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
         acc_ff       <= acc_in;
         if (accept && req_ch.req_type == EDGE_RISE) begin
            rise_ff <= req_ch.capture_time;
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_TICKS_PER_US: ticks_ff <= csr_wdata[TICKS_W-1:0];
               CSR_WIDTH_LIMIT:  limit_ff <= csr_wdata[WIDTH_W-1:0];
               default: ;
            endcase
         end
      end
      step_ff <= step_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.filtered_width  = held_ff;
   assign rsp_ch.median_accepted = acc_ff;

   a_median_unique: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SELECT |-> $onehot(mid_hit))
      else $error("median rank not unique");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside divide phase");

   a_rank_length: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RANK && step_ff == RANK_LAST |=> state_ff == ST_SELECT)
      else $error("rank phase did not end after a full rotation");

endmodule

[verif/pwmf_median_checker.sv]
// ----------------------------------------------------------------------------
// pwmf_median_checker
// Watches the capture and result channels and the register port, keeps its
// own copy of the pulse width window, and compares every result word with
// the width and accept flag it predicts. Hands a mismatch count and the
// number of results still due to the testbench top.
// ----------------------------------------------------------------------------
module pwmf_median_checker #(
   parameter int WINDOW_SIZE = 11
) (
   input  logic                            clock,
   input  logic                            reset,
   pwmf_req_if                             req_ch,
   pwmf_rsp_if                             rsp_ch,
   input  logic                            csr_we,
   input  logic [pwmf_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [pwmf_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatches,
   output int                              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import pwmf_pkg::*;

   typedef struct packed {
      logic [WIDTH_W-1:0] width;
      logic               accepted;
   } filter_word_type;

   filter_word_type      due_words[$];

   logic [TICKS_W-1:0]   ticks_per_us;
   logic [WIDTH_W-1:0]   limit_us;
   logic [TIME_W-1:0]    rise_stamp;
   logic [WIDTH_W-1:0]   window[WINDOW_SIZE];
   int                   slot;
   logic [WIDTH_W-1:0]   held_width;

   function automatic logic [WIDTH_W-1:0] span_to_us(input logic [TIME_W-1:0] span,
                                                     input logic [TICKS_W-1:0] ticks);
      logic [TIME_W-1:0] quotient;
      if (ticks == '0) begin
         return WIDTH_MAX;
      end
      quotient = span / TIME_W'(ticks);
      return (quotient > TIME_W'(WIDTH_MAX)) ? WIDTH_MAX : quotient[WIDTH_W-1:0];
   endfunction

   function automatic logic [WIDTH_W-1:0] window_median();
      logic [WIDTH_W-1:0] sorted[WINDOW_SIZE];
      logic [WIDTH_W-1:0] held;
      int                 j;
      sorted = window;
      for (int i = 1; i < WINDOW_SIZE; i++) begin
         held = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > held) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = held;
      end
      return sorted[WINDOW_SIZE / 2];
   endfunction

   always @(posedge clock) begin
      filter_word_type    got;
      filter_word_type    want;
      logic [WIDTH_W-1:0] median;
      if (reset) begin
         ticks_per_us = TICKS_RESET;
         limit_us     = LIMIT_RESET;
         rise_stamp   = '0;
         slot         = 0;
         held_width   = '0;
         foreach (window[i]) window[i] = '0;
         due_words.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_TICKS_PER_US: ticks_per_us = csr_wdata[TICKS_W-1:0];
               CSR_WIDTH_LIMIT:  limit_us     = csr_wdata[WIDTH_W-1:0];
               default: ;
            endcase
         end

         if (rsp_ch.valid && rsp_ch.ready) begin
            got.width    = rsp_ch.filtered_width;
            got.accepted = rsp_ch.median_accepted;
            if (due_words.size() == 0) begin
               $error("unexpected result word: filtered_width %0d, median_accepted %0d",
                      got.width, got.accepted);
               mismatches++;
            end else begin
               want = due_words.pop_front();
               if (got.width !== want.width) begin
                  $error("filtered_width: expected %0d, got %0d", want.width, got.width);
                  mismatches++;
               end
               if (got.accepted !== want.accepted) begin
                  $error("median_accepted: expected %0d, got %0d",
                         want.accepted, got.accepted);
                  mismatches++;
               end
            end
         end

         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.req_type == EDGE_RISE) begin
               rise_stamp = req_ch.capture_time;
            end else begin
               window[slot] = span_to_us(req_ch.capture_time - rise_stamp, ticks_per_us);
               slot = (slot + 1) % WINDOW_SIZE;
               median = window_median();
               want.accepted = (median < limit_us);
               if (want.accepted) begin
                  held_width = median;
               end
               want.width = held_width;
               due_words.push_back(want);
            end
         end
      end
      outstanding = due_words.size();
   end

endmodule

[verif/pulse_width_median_filter_tb.sv]
// ----------------------------------------------------------------------------
// pulse_width_median_filter_tb
// Drives capture edge words into the median filter: a directed pass over
// wrap-around, repeated rises, orphan falls, saturation, zero divisor and
// limit extremes, then random pulse trains under changing register settings
// with random idling on both channels. The checker beside the block judges
// every result word.
// ----------------------------------------------------------------------------
module pulse_width_median_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pwmf_pkg::*;

   localparam int WINDOW     = 11;
   localparam int SETTLE     = WINDOW + 29;
   localparam int RAND_ITEMS = 1800;
   localparam int PHASE_LEN  = 150;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int                    mismatches;
   int                    outstanding;
   int                    items_sent;
   bit                    gaps_on;
   logic [TICKS_W-1:0]    cur_ticks;

   pwmf_req_if req_ch ();
   pwmf_rsp_if rsp_ch ();

   pulse_width_median_filter #(
      .WINDOW_SIZE (WINDOW)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   pwmf_median_checker #(
      .WINDOW_SIZE (WINDOW)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= !gaps_on || ($urandom_range(99) >= 32);
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic push_edge(input logic kind, input logic [TIME_W-1:0] stamp);
      while (gaps_on && $urandom_range(99) < 32) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= kind;
      req_ch.capture_time <= stamp;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic drain(input int max_cycles);
      int n;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      n = 0;
      while (outstanding != 0 && n < max_cycles) begin
         @(posedge clock);
         n++;
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_regs(input logic [CSR_DATA_W-1:0] ticks_word,
                             input logic [WIDTH_W-1:0] limit);
      drain(200000);
      cur_ticks = ticks_word[TICKS_W-1:0];
      csr_we    <= 1'b1;
      csr_addr  <= CSR_TICKS_PER_US;
      csr_wdata <= ticks_word;
      @(posedge clock);
      csr_addr  <= CSR_WIDTH_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic pulse(input logic [TIME_W-1:0] rise_at, input logic [TIME_W-1:0] span);
      push_edge(EDGE_RISE, rise_at);
      push_edge(EDGE_FALL, rise_at + span);
   endtask

   task automatic random_phase(input int target);
      int                pick;
      int                us;
      logic [TIME_W-1:0] rise_at;
      logic [TIME_W-1:0] span;
      while (items_sent < target) begin
         pick    = $urandom_range(99);
         rise_at = $urandom();
         if (pick < 80) begin
            us   = (pick < 65) ? $urandom_range(0, 6000) : $urandom_range(0, 70000);
            span = TIME_W'(us) * TIME_W'(cur_ticks)
                   + ((cur_ticks == '0) ? $urandom_range(0, 255)
                                        : $urandom_range(0, cur_ticks - 1));
            if (pick < 5) begin
               span = $urandom();
            end
            pulse(rise_at, span);
         end else if (pick < 88) begin
            push_edge(EDGE_FALL, $urandom());
         end else if (pick < 94) begin
            push_edge(EDGE_RISE, $urandom());
         end else begin
            push_edge(EDGE_RISE, $urandom());
            pulse(rise_at, TIME_W'($urandom_range(0, 400000)));
         end
      end
   endtask

   initial begin
      logic [TICKS_W-1:0] tk;
      logic [WIDTH_W-1:0] lim;
      int                 phase;
      int                 target;

      req_ch.valid        <= 1'b0;
      req_ch.req_type     <= EDGE_RISE;
      req_ch.capture_time <= '0;
      csr_we              <= 1'b0;
      csr_addr            <= CSR_TICKS_PER_US;
      csr_wdata           <= '0;
      items_sent = 0;
      gaps_on    = 1'b1;
      cur_ticks  = TICKS_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values
      push_edge(EDGE_FALL, 32'd800);
      pulse(32'hFFFF_FF00, 32'h0000_0200);
      push_edge(EDGE_RISE, 32'd100);
      pulse(32'd1000, 32'd4000);
      pulse(32'd0, 32'hFFFF_FFFF);
      pulse(32'h5555_5555, 32'd0);

      // zero divisor, upper data bits set
      write_regs(16'hFF00, 16'hFFFF);
      pulse(32'd7, 32'd2);
      push_edge(EDGE_FALL, 32'hAAAA_AAAA);
      push_edge(EDGE_FALL, 32'd0);

      write_regs(16'd255, 16'd0);
      pulse(32'd0, 32'hFFFF_FFFF);
      pulse(32'd1, 32'd255);

      write_regs(16'd1, 16'd1);
      pulse(32'hFFFF_FFFF, 32'd1);
      push_edge(EDGE_FALL, 32'hFFFF_FFFF);

      target = items_sent;
      phase  = 0;
      while (items_sent < RAND_ITEMS + 21) begin
         case (phase % 6)
            0:       tk = 8'd80;
            1:       tk = 8'd1;
            2:       tk = 8'd255;
            3:       tk = 8'd0;
            default: tk = TICKS_W'($urandom_range(1, 255));
         endcase
         case (phase % 4)
            0:       lim = 16'hFFFF;
            1:       lim = (phase % 8 == 1) ? 16'd0 : WIDTH_W'($urandom_range(1, 200));
            default: lim = WIDTH_W'($urandom_range(0, 6000));
         endcase
         write_regs({8'($urandom()), tk}, lim);
         gaps_on = (phase != 4);
         target += PHASE_LEN;
         random_phase(target);
         phase++;
      end

      gaps_on = 1'b1;
      drain(200000);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/pwmf_pkg.sv
hw/rtl/pwmf_channels.sv
hw/rtl/pwmf_divider.sv
hw/rtl/pwmf_cell.sv
hw/rtl/pulse_width_median_filter.sv
verif/pwmf_median_checker.sv
verif/pulse_width_median_filter_tb.sv
